// ----- rtl/trie_dictionary_word_matcher_core_macros.svh -----
// assertion macros for the word matcher
`ifndef TRIE_DICTIONARY_WORD_MATCHER_CORE_MACROS_SVH
`define TRIE_DICTIONARY_WORD_MATCHER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TDWM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tdwm check failed");
`define TDWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tdwm check failed");
`else
`define TDWM_ASSERT_IMPL(label, ante, cons)
`define TDWM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/tdwm_pkg.sv -----
package tdwm_pkg;
    localparam int DICT_DEPTH_DEF   = 65536;
    localparam int MAX_WALKS_DEF    = 32;
    localparam int MAX_TEXT_LEN_DEF = 65536;

    localparam logic [1:0] OP_DICT_WRITE = 2'd0;
    localparam logic [1:0] OP_TEXT_BYTE  = 2'd1;
    localparam logic [1:0] OP_NEW_STRING = 2'd2;

    localparam logic [22:0] ROOT_NODE = 23'd1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] dict_addr;
        logic [31:0] dict_word;
        logic [7:0]  text_byte;
    } in_t;

    typedef struct packed {
        logic        match_valid;
        logic [15:0] word_start;
        logic [15:0] word_end;
        logic        walk_overflow;
        logic        last_result;
    } out_t;

    typedef struct packed {
        logic [22:0] node;
        logic [15:0] start;
    } walk_t;
endpackage

// ----- rtl/trie_dictionary_word_matcher_core.sv -----
// Trie dictionary word matcher. Dictionary writes and begin-new-string complete in S_IDLE.
// A text byte opens a walk at the root, then advances each live walk: a null pointer
// drops it, a table node is indexed by the byte, a list node is binary-searched in k probes
// (k up to 31), one dictionary read per probe through its single read port; each match
// gives a result beat, and a final beat closes the byte. Walks live packed in a walk
// memory of MAX_WALKS slots and are compacted in place as they are advanced. Results
// queue in one output register; the next input beat is taken while a byte's final beat waits.
`include "trie_dictionary_word_matcher_core_macros.svh"
module trie_dictionary_word_matcher_core #(
    parameter int DICT_DEPTH   = tdwm_pkg::DICT_DEPTH_DEF,
    parameter int MAX_WALKS    = tdwm_pkg::MAX_WALKS_DEF,
    parameter int MAX_TEXT_LEN = tdwm_pkg::MAX_TEXT_LEN_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  tdwm_pkg::in_t s_payload,
    output logic          m_valid,
    input  logic          m_ready,
    output tdwm_pkg::out_t m_payload
);
    import tdwm_pkg::*;

    localparam int AW = $clog2(DICT_DEPTH);
    localparam int WW = $clog2(MAX_WALKS);
    localparam int PW = $clog2(MAX_TEXT_LEN);
    localparam logic [32:0] DEPTH33 = 33'(DICT_DEPTH);
    localparam logic [WW:0] WALKS_N = (WW+1)'(MAX_WALKS);
    localparam logic [PW-1:0] POS_LAST = PW'(MAX_TEXT_LEN - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_WRD   = 4'd1;
    localparam logic [3:0] S_WWAIT = 4'd2;
    localparam logic [3:0] S_HDR   = 4'd3;
    localparam logic [3:0] S_BSRD  = 4'd4;
    localparam logic [3:0] S_BSCMP = 4'd5;
    localparam logic [3:0] S_TENT  = 4'd6;
    localparam logic [3:0] S_EMIT  = 4'd7;
    localparam logic [3:0] S_LAST  = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [WW:0] cnt_reg, cnt_next;
    logic [WW:0] n_reg, n_next;
    logic [WW:0] i_reg, i_next;
    logic [WW:0] w_reg, w_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [7:0]  ch_reg, ch_next;
    logic        ovf_reg, ovf_next;
    logic [22:0] node_reg, node_next;
    logic [15:0] start_reg, start_next;
    logic signed [32:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [31:0] mid_reg, mid_next;
    logic        oor_reg;
    logic        out_valid_reg, out_valid_next;
    out_t        out_reg, out_next;

    logic          d_we;
    logic [AW-1:0] d_waddr;
    logic [32:0]   d_raddr33;
    logic [31:0]   d_rdata, dword;
    logic          w_we;
    logic [WW-1:0] w_waddr, w_raddr;
    walk_t         w_wdata, w_rdata;

    logic          out_free;
    logic signed [33:0] mid_sum;
    logic [7:0]    tch;

    tdwm_ram #(.WIDTH(32), .DEPTH(DICT_DEPTH)) u_dict (
        .aclk(aclk), .we(d_we), .waddr(d_waddr), .wdata(s_payload.dict_word),
        .raddr(d_raddr33[AW-1:0]), .rdata(d_rdata)
    );

    tdwm_ram #(.WIDTH($bits(walk_t)), .DEPTH(MAX_WALKS)) u_walk (
        .aclk(aclk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .raddr(w_raddr), .rdata(w_rdata)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;
    assign out_free  = !out_valid_reg || m_ready;
    assign dword     = oor_reg ? 32'd0 : d_rdata;
    assign tch       = dword[31:24];
    assign mid_sum   = 34'(lo_reg) + 34'(hi_reg);

    // dictionary write port
    always_comb begin
        d_we    = s_valid && s_ready && (s_payload.operation == OP_DICT_WRITE)
                  && (33'(s_payload.dict_addr) < DEPTH33);
        d_waddr = s_payload.dict_addr[AW-1:0];
    end

    // dictionary read address per step of the walk
    always_comb begin
        unique case (state_reg)
            S_WWAIT: d_raddr33 = 33'(w_rdata.node) - 33'd1;
            S_HDR:   d_raddr33 = 33'(node_reg) + 33'(ch_reg);
            S_BSRD:  d_raddr33 = 33'(node_reg) + 33'(mid_next);
            default: d_raddr33 = 33'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        oor_reg <= (d_raddr33 >= DEPTH33);
    end

    // main sequencer
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        w_next         = w_reg;
        pos_next       = pos_reg;
        ch_next        = ch_reg;
        ovf_next       = ovf_reg;
        node_next      = node_reg;
        start_next     = start_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        w_we           = 1'b0;
        w_waddr        = w_reg[WW-1:0];
        w_wdata        = '{node: dword[22:0], start: start_reg};
        w_raddr        = i_reg[WW-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (s_payload.operation)
                        OP_NEW_STRING: begin
                            cnt_next = '0;
                            pos_next = '0;
                        end
                        OP_TEXT_BYTE: begin
                            ch_next  = s_payload.text_byte;
                            ovf_next = (cnt_reg >= WALKS_N);
                            i_next   = '0;
                            w_next   = '0;
                            n_next   = cnt_reg;
                            if (cnt_reg < WALKS_N) begin
                                w_we    = 1'b1;
                                w_waddr = cnt_reg[WW-1:0];
                                w_wdata = '{node: ROOT_NODE, start: 16'(pos_reg)};
                                n_next  = cnt_reg + 1'b1;
                            end
                            state_next = S_WRD;
                        end
                        default: ;
                    endcase
                end
            end
            S_WRD: begin
                state_next = (i_reg == n_reg) ? S_LAST : S_WWAIT;
            end
            S_WWAIT: begin
                node_next  = w_rdata.node;
                start_next = w_rdata.start;
                if (w_rdata.node == 23'd0) begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_WRD;
                end else begin
                    state_next = S_HDR;
                end
            end
            S_HDR: begin
                lo_next = '0;
                hi_next = $signed({2'b00, dword[30:0]}) - 33'sd1;
                if (dword[31]) begin
                    state_next = S_TENT;
                end else if (dword[30:0] == 31'd0) begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_WRD;
                end else begin
                    state_next = S_BSRD;
                end
            end
            S_BSRD: begin
                mid_next   = mid_sum[32:1];
                state_next = S_BSCMP;
            end
            S_BSCMP, S_TENT: begin
                logic found, dead;
                found = 1'b0;
                dead  = 1'b0;
                if (state_reg == S_TENT) begin
                    found = (tch != 8'd0);
                    dead  = !found;
                end else if (ch_reg < tch) begin
                    hi_next = $signed({1'b0, mid_reg}) - 33'sd1;
                    dead    = (lo_reg > hi_next);
                end else if (ch_reg > tch) begin
                    lo_next = $signed({1'b0, mid_reg}) + 33'sd1;
                    dead    = (lo_next > hi_reg);
                end else begin
                    found = 1'b1;
                end
                if (found) begin
                    w_we   = 1'b1;
                    w_next = w_reg + 1'b1;
                    i_next = i_reg + 1'b1;
                    state_next = dword[23] ? S_EMIT : S_WRD;
                end else if (dead) begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_WRD;
                end else begin
                    state_next = S_BSRD;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next = '{match_valid: 1'b1, word_start: start_reg,
                                 word_end: 16'(pos_reg), walk_overflow: ovf_reg,
                                 last_result: 1'b0};
                    state_next = S_WRD;
                end
            end
            S_LAST: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next = '{match_valid: 1'b0, word_start: 16'd0,
                                 word_end: 16'(pos_reg), walk_overflow: ovf_reg,
                                 last_result: 1'b1};
                    cnt_next   = w_reg;
                    pos_next   = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
            i_reg         <= '0;
            w_reg         <= '0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            w_reg         <= w_next;
        end
    end

    // walk payload
    always_ff @(posedge aclk) begin
        ch_reg    <= ch_next;
        ovf_reg   <= ovf_next;
        node_reg  <= node_next;
        start_reg <= start_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        out_reg   <= out_next;
    end

    // checks
    `TDWM_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_reg <= WALKS_N)
    `TDWM_ASSERT_IMPL(a_compact_order, state_reg != S_IDLE, w_reg <= i_reg && i_reg <= n_reg)
    `TDWM_ASSERT_IMPL(a_last_no_match, out_valid_reg && out_reg.last_result, !out_reg.match_valid)
    `TDWM_ASSERT_NEXT(a_pos_step, state_reg == S_LAST && out_free, state_reg == S_IDLE)
endmodule

// ----- rtl/tdwm_ram.sv -----
module tdwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
    import tdwm_pkg::*;

    localparam int WALK_SLOTS = 32;
    localparam int MAX_NODES  = 6;
    localparam int HOLD_CYCLES = 600;
    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam logic [22:0] TOP_TABLE = 23'h00FFF0;
    localparam logic [22:0] FAR_NODE  = 23'h7FFFF0;

    typedef enum {WALK_DEAD, WALK_ON, WALK_HIT} walk_fate_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_payload;

    trie_dictionary_word_matcher_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

    // beats waiting to be sent and results still owed by the block
    in_t beat_q[$];
    out_t match_q[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_on = 1'b0;

    // mirror of the matcher state
    logic [31:0] dict_mem [int];
    logic [22:0] walk_node [WALK_SLOTS];
    logic [15:0] walk_from [WALK_SLOTS];
    int walk_cnt = 0;
    logic [15:0] text_pos = '0;

    // current trie shape, kept to build well-formed text
    logic [7:0] alph [9] = '{8'h01, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h7A, 8'h80, 8'hFF};
    int n_nodes;
    int node_cnt [MAX_NODES];
    int node_dep [MAX_NODES];
    int node_hdr [MAX_NODES];
    logic [7:0] ent_ch [MAX_NODES][9];
    bit ent_end [MAX_NODES][9];
    int ent_kid [MAX_NODES][9];
    logic [22:0] ent_leaf [MAX_NODES][9];

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic logic [31:0] dict_rd(longint a);
        if (a < 65536 && dict_mem.exists(int'(a))) return dict_mem[int'(a)];
        return 32'h0;
    endfunction

    // one step of a walk through the packed trie
    function automatic walk_fate_t step_walk(logic [22:0] node, logic [7:0] ch,
                                             output logic [22:0] nx);
        logic [31:0] hdr;
        logic [31:0] e;
        longint lo, hi, m;
        bit found;
        nx = '0;
        if (node == 0) return WALK_DEAD;
        hdr = dict_rd(longint'(node) - 1);
        e = '0;
        if (hdr[31]) begin
            e = dict_rd(longint'(node) + longint'(ch));
            if (e[31:24] == 0) return WALK_DEAD;
        end else begin
            lo = 0;
            hi = longint'(hdr[30:0]) - 1;
            found = 0;
            while (lo <= hi && !found) begin
                m = (lo + hi) / 2;
                e = dict_rd(longint'(node) + m);
                if (ch < e[31:24]) hi = m - 1;
                else if (ch > e[31:24]) lo = m + 1;
                else found = 1;
            end
            if (!found) return WALK_DEAD;
        end
        nx = e[22:0];
        return e[23] ? WALK_HIT : WALK_ON;
    endfunction

    // expected results of one accepted beat
    function automatic void predict_matches(in_t b);
        logic [22:0] nx;
        walk_fate_t st;
        bit ovf;
        int w;
        out_t r;
        case (b.operation)
            OP_DICT_WRITE: dict_mem[int'(b.dict_addr)] = b.dict_word;
            OP_NEW_STRING: begin
                walk_cnt = 0;
                text_pos = '0;
            end
            OP_TEXT_BYTE: begin
                ovf = walk_cnt >= WALK_SLOTS;
                if (!ovf) begin
                    walk_node[walk_cnt] = ROOT_NODE;
                    walk_from[walk_cnt] = text_pos;
                    walk_cnt++;
                end
                w = 0;
                for (int i = 0; i < walk_cnt; i++) begin
                    st = step_walk(walk_node[i], b.text_byte, nx);
                    if (st != WALK_DEAD) begin
                        if (st == WALK_HIT) begin
                            r = '{1'b1, walk_from[i], text_pos, ovf, 1'b0};
                            match_q.push_back(r);
                        end
                        walk_node[w] = nx;
                        walk_from[w] = walk_from[i];
                        w++;
                    end
                end
                walk_cnt = w;
                r = '{1'b0, 16'h0, text_pos, ovf, 1'b1};
                match_q.push_back(r);
                text_pos = text_pos + 16'd1;
            end
            default: ;
        endcase
    endfunction

    function automatic in_t mk_beat(logic [1:0] op, logic [7:0] ch);
        in_t b;
        b.operation = op;
        b.dict_addr = 16'($urandom);
        b.dict_word = $urandom;
        b.text_byte = ch;
        return b;
    endfunction

    task automatic push_write(int addr, logic [31:0] word);
        in_t b;
        b = mk_beat(OP_DICT_WRITE, 8'($urandom));
        b.dict_addr = 16'(addr);
        b.dict_word = word;
        beat_q.push_back(b);
    endtask

    // table node near the top of memory, entries past the end read as absent
    task automatic load_top_table();
        logic [31:0] word;
        logic [22:0] p;
        push_write(int'(TOP_TABLE) - 1, 32'h8000_0000);
        for (int c = 0; c < 16; c++) begin
            case ($urandom_range(0, 3))
                0: p = '0;
                1: p = ROOT_NODE;
                2: p = FAR_NODE;
                default: p = TOP_TABLE;
            endcase
            word = {($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255)),
                    1'($urandom_range(0, 1)), p};
            push_write(int'(TOP_TABLE) + c, word);
        end
    endtask

    // random list trie, laid out from address 0 so the root pointer is 1
    task automatic build_trie();
        int addr, m, j;
        logic [22:0] p;
        logic [31:0] word;
        n_nodes = 1;
        node_dep[0] = 0;
        for (int n = 0; n < n_nodes; n++) begin
            node_cnt[n] = 0;
            if (n != 0 && $urandom_range(0, 9) == 0) continue;
            m = $urandom;
            for (int a = 0; a < 9; a++) begin
                if (!(m[a] || (n == 0 && (alph[a] == 8'h7A || alph[a] == 8'h01)))) continue;
                j = node_cnt[n];
                node_cnt[n] = j + 1;
                ent_ch[n][j] = alph[a];
                ent_end[n][j] = 1'($urandom_range(0, 1));
                ent_kid[n][j] = -1;
                ent_leaf[n][j] = '0;
                if (n == 0 && alph[a] == 8'h7A) begin
                    // loops back to the root and always ends a word
                    ent_end[n][j] = 1'b1;
                    ent_kid[n][j] = 0;
                end else if (n == 0 && alph[a] == 8'h01) begin
                    // jumps into the table node at the top of memory
                    ent_leaf[n][j] = TOP_TABLE;
                end else if (node_dep[n] < 3 && n_nodes < MAX_NODES
                             && $urandom_range(0, 2) != 0) begin
                    ent_kid[n][j] = n_nodes;
                    node_dep[n_nodes] = node_dep[n] + 1;
                    n_nodes++;
                end else begin
                    case ($urandom_range(0, 3))
                        2: ent_leaf[n][j] = FAR_NODE;
                        3: ent_leaf[n][j] = TOP_TABLE;
                        default: ent_leaf[n][j] = '0;
                    endcase
                end
            end
        end
        addr = 0;
        for (int n = 0; n < n_nodes; n++) begin
            node_hdr[n] = addr;
            addr += 1 + node_cnt[n];
        end
        for (int n = 0; n < n_nodes; n++) begin
            push_write(node_hdr[n], 32'(node_cnt[n]));
            for (int k = 0; k < node_cnt[n]; k++) begin
                p = ent_kid[n][k] >= 0 ? 23'(node_hdr[ent_kid[n][k]] + 1)
                                       : ent_leaf[n][k];
                word = {ent_ch[n][k], ent_end[n][k], p};
                push_write(node_hdr[n] + 1 + k, word);
            end
        end
        beat_q.push_back(mk_beat(OP_NEW_STRING, 8'($urandom)));
    endtask

    // mostly dictionary words and root loops, some noise
    task automatic add_text(int n);
        int made, r, cur, len, j;
        made = 0;
        while (made < n) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                cur = 0;
                len = 0;
                while (cur >= 0 && node_cnt[cur] > 0 && len < 8) begin
                    j = $urandom_range(0, node_cnt[cur] - 1);
                    beat_q.push_back(mk_beat(OP_TEXT_BYTE, ent_ch[cur][j]));
                    cur = ent_kid[cur][j];
                    len++;
                    made++;
                end
            end else if (r < 62) begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    beat_q.push_back(mk_beat(OP_TEXT_BYTE, 8'h7A));
                made += len;
            end else if (r < 76) begin
                beat_q.push_back(mk_beat(OP_TEXT_BYTE, 8'($urandom_range(1, 255))));
                made++;
            end else if (r < 86) begin
                beat_q.push_back(mk_beat(OP_TEXT_BYTE, 8'h01));
                beat_q.push_back(mk_beat(OP_TEXT_BYTE, 8'($urandom_range(1, 15))));
                made += 2;
            end else if (r < 91) begin
                beat_q.push_back(mk_beat(OP_NEW_STRING, 8'($urandom)));
            end else if (r < 95) begin
                beat_q.push_back(mk_beat(OP_RESERVED, 8'($urandom)));
            end else begin
                // away from every node that a walk can reach
                push_write($urandom_range(16'h1000, 16'h8000), $urandom);
            end
        end
    endtask

    task automatic drain_sender();
        while (beat_q.size() != 0 || s_valid) @(posedge aclk);
    endtask

    // sender side: predict on each accepted beat, then offer the next
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_matches(s_payload);
            if (!s_valid || s_ready) begin
                if (beat_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_payload <= beat_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side: compare each beat against the oldest expectation
    always @(posedge aclk) begin
        out_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (match_q.size() == 0) begin
                $error("unexpected result beat %p", m_payload);
                errors++;
            end else begin
                exp_r = match_q.pop_front();
                if (m_payload.match_valid !== exp_r.match_valid) begin
                    $error("match_valid exp %0d got %0d", exp_r.match_valid,
                           m_payload.match_valid);
                    errors++;
                end
                if (m_payload.word_start !== exp_r.word_start) begin
                    $error("word_start exp %0d got %0d", exp_r.word_start,
                           m_payload.word_start);
                    errors++;
                end
                if (m_payload.word_end !== exp_r.word_end) begin
                    $error("word_end exp %0d got %0d", exp_r.word_end, m_payload.word_end);
                    errors++;
                end
                if (m_payload.walk_overflow !== exp_r.walk_overflow) begin
                    $error("walk_overflow exp %0d got %0d", exp_r.walk_overflow,
                           m_payload.walk_overflow);
                    errors++;
                end
                if (m_payload.last_result !== exp_r.last_result) begin
                    $error("last_result exp %0d got %0d", exp_r.last_result,
                           m_payload.last_result);
                    errors++;
                end
            end
        end
        m_ready <= !hold_on && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        wait (hold_req);
        @(posedge aclk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_on <= 1'b0;
    end

    initial begin
        #10ms;
        $display("Regression FAIL");
        $finish;
    end

    // stimulus phases
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        load_top_table();
        build_trie();

        // enough root loops to fill every walk slot and drop new walks
        for (int i = 0; i < 34; i++) beat_q.push_back(mk_beat(OP_TEXT_BYTE, 8'h7A));
        beat_q.push_back(mk_beat(OP_NEW_STRING, 8'($urandom)));
        beat_q.push_back(mk_beat(OP_TEXT_BYTE, 8'h01));
        beat_q.push_back(mk_beat(OP_TEXT_BYTE, 8'hFF));
        beat_q.push_back(mk_beat(OP_TEXT_BYTE, 8'h80));
        beat_q.push_back(mk_beat(OP_TEXT_BYTE, 8'h61));
        beat_q.push_back(mk_beat(OP_TEXT_BYTE, 8'h62));
        beat_q.push_back(mk_beat(OP_RESERVED, 8'hFF));
        beat_q.push_back(mk_beat(OP_NEW_STRING, 8'($urandom)));
        add_text(12);
        drain_sender();

        send_idle_pct = 55;
        add_text(12);
        drain_sender();

        send_idle_pct = 0;
        recv_stall_pct = 55;
        add_text(12);
        hold_req = 1'b1;
        drain_sender();

        // fresh trie, light idling on both sides
        send_idle_pct = 6;
        recv_stall_pct = 6;
        build_trie();
        add_text(12);
        drain_sender();

        while (match_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
